// ----- rtl/core/nba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next-fit bitmap ID allocator package
// Shared sizes, codes and control structs for the allocator core.
// ----------------------------------------------------------------------------
package nba_pkg;

   localparam int MAX_IDS    = 1024;
   localparam int WORD_BITS  = 32;
   localparam int WORD_COUNT = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BIT_IDX_W  = $clog2(WORD_BITS);
   localparam int ID_W       = $clog2(MAX_IDS);
   localparam int CNT_W      = ID_W + 1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_RANGE   = 2'd2,
      STATUS_UNALLOC = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic cfg_write;
      logic free_exec;
      logic alloc_full;
      logic scan_init;
      logic scan_step;
   } dp_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic pool_empty;
      logic found;
   } dp_status_type;

endpackage

// ----- rtl/core/nba_channels.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator channel interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface nba_req_if;
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [nba_pkg::ID_W-1:0]  id;

   modport source (output valid, output operation, output id, input ready);
   modport sink   (input valid, input operation, input id, output ready);
endinterface

interface nba_rsp_if;
   logic                       valid;
   logic                       ready;
   nba_pkg::status_type        status;
   logic [nba_pkg::ID_W-1:0]   id_res;
   logic [nba_pkg::CNT_W-1:0]  free_left;

   modport source (output valid, output status, output id_res, output free_left,
                   input ready);
   modport sink   (input valid, input status, input id_res, input free_left,
                   output ready);
endinterface

interface nba_csr_if;
   logic                       valid;
   logic                       ready;
   logic [nba_pkg::CNT_W-1:0]  id_count;

   modport source (output valid, output id_count, input ready);
   modport sink   (input valid, input id_count, output ready);
endinterface

// ----- rtl/core/next_fit_bitmap_id_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next-fit bitmap ID allocator core
// Hands out and takes back IDs 0..id_count-1 kept as a used-bit bitmap.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  req_ch    in         operation (0 allocate, 1 free), id
//  rsp_ch    out        status, id_res, free_left
//  csr_ch    in         id_count (writing it clears the pool)
//
// A free request does its work in the accept cycle and its response shows in
// the next cycle. An allocate request scans one bitmap word per cycle through a
// single priority encoder until it finds a free ID; a full pool answers at once.
// Only one request is in the block at a time: a new request is accepted once
// the response has been taken. Reset is synchronous and restores a pool of
// 1024 free IDs with the search starting at ID 0.
//
module next_fit_bitmap_id_allocator_core (
   input  logic       clock,
   input  logic       reset,
   nba_req_if.sink    req_ch,
   nba_rsp_if.source  rsp_ch,
   nba_csr_if.sink    csr_ch
);
   import nba_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type dp_status;

   // The controller owns all handshakes; the datapath only sees commands.
   nba_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .req_ready     (req_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .csr_valid     (csr_ch.valid),
      .csr_ready     (csr_ch.ready),
      .cmd           (cmd),
      .status        (dp_status)
   );

   // The bitmap, counters and response registers live in the datapath. The
   // response registers hold steady while the response waits to be taken.
   nba_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (dp_status),
      .req_id        (req_ch.id),
      .csr_id_count  (csr_ch.id_count),
      .rsp_status    (rsp_ch.status),
      .rsp_id_res    (rsp_ch.id_res),
      .rsp_free_left (rsp_ch.free_left)
   );

endmodule

// ----- rtl/core/nba_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences one request at a time: accept, optional word scan, response.
// ----------------------------------------------------------------------------
module nba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_operation,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   output nba_pkg::dp_cmd_type    cmd,
   input  nba_pkg::dp_status_type status
);
   import nba_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      req_take;
   logic      csr_take;

   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign rsp_valid = (state_ff == ST_DONE);
   assign csr_take  = csr_valid && csr_ready;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_operation == OP_FREE || status.pool_empty) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.found) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.cfg_write = csr_take;
            if (req_take) begin
               cmd.free_exec  = (req_operation == OP_FREE);
               cmd.alloc_full = (req_operation == OP_ALLOC) && status.pool_empty;
               cmd.scan_init  = (req_operation == OP_ALLOC) && !status.pool_empty;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A scan only starts with a free ID in the pool, so it never runs dry.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !status.pool_empty)
      else $error("scan running on an empty pool");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.cfg_write, cmd.free_exec, cmd.alloc_full, cmd.scan_init,
                cmd.scan_step}))
      else $error("more than one datapath command at once");

endmodule

// ----- rtl/core/nba_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator datapath
// Used-bit bitmap, counters, word scan with priority encoder, response regs.
// ----------------------------------------------------------------------------
module nba_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  nba_pkg::dp_cmd_type          cmd,
   output nba_pkg::dp_status_type       status,
   input  logic [nba_pkg::ID_W-1:0]     req_id,
   input  logic [nba_pkg::CNT_W-1:0]    csr_id_count,
   output nba_pkg::status_type          rsp_status,
   output logic [nba_pkg::ID_W-1:0]     rsp_id_res,
   output logic [nba_pkg::CNT_W-1:0]    rsp_free_left
);
   import nba_pkg::*;

   // Lowest set bit: {hit, index}.
   function automatic logic [BIT_IDX_W:0] find_first(input logic [WORD_BITS-1:0] v);
      logic [BIT_IDX_W:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = {1'b1, BIT_IDX_W'(i)};
         end
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > CNT_W'(MAX_IDS)) begin
         r = CNT_W'(MAX_IDS);
      end
      return r;
   endfunction

   logic [WORD_BITS-1:0]  used_ff [WORD_COUNT];
   logic [CNT_W-1:0]      id_count_ff;
   logic [ID_W-1:0]       last_id_ff;
   logic [CNT_W-1:0]      free_total_ff;
   logic [ID_W-1:0]       search_start_ff;
   logic [WORD_IDX_W-1:0] scan_word_ff;
   logic                  scan_first_ff;
   status_type            rsp_status_ff;
   logic [ID_W-1:0]       rsp_id_ff;

   logic [CNT_W-1:0]      new_count;
   logic [WORD_BITS-1:0]  scan_data;
   logic [WORD_BITS-1:0]  low_mask;
   logic [WORD_BITS-1:0]  high_mask;
   logic [BIT_IDX_W:0]    pick;
   logic [ID_W-1:0]       found_id;
   logic                  scan_hit;
   logic [WORD_IDX_W-1:0] last_word;
   logic [WORD_IDX_W-1:0] free_word;
   logic [BIT_IDX_W-1:0]  free_bit;
   logic                  free_in_range;
   logic                  free_is_used;

   assign new_count = clamp_count(csr_id_count);
   assign last_word = last_id_ff[ID_W-1:BIT_IDX_W];

   // Scan of one word: first visit skips IDs below the start point, the last
   // word skips IDs at or above id_count.
   assign scan_data = used_ff[scan_word_ff];
   assign low_mask  = scan_first_ff ?
                      ({WORD_BITS{1'b1}} << search_start_ff[BIT_IDX_W-1:0]) :
                      {WORD_BITS{1'b1}};
   assign high_mask = (scan_word_ff == last_word) ?
                      ({WORD_BITS{1'b1}} >> (BIT_IDX_W'(WORD_BITS - 1) -
                                             last_id_ff[BIT_IDX_W-1:0])) :
                      {WORD_BITS{1'b1}};
   assign pick      = find_first(~scan_data & low_mask & high_mask);
   assign scan_hit  = cmd.scan_step && pick[BIT_IDX_W];
   assign found_id  = ID_W'({scan_word_ff, pick[BIT_IDX_W-1:0]});

   assign free_word     = req_id[ID_W-1:BIT_IDX_W];
   assign free_bit      = req_id[BIT_IDX_W-1:0];
   assign free_in_range = ({1'b0, req_id} < id_count_ff);
   assign free_is_used  = used_ff[free_word][free_bit];

   assign status.pool_empty = (free_total_ff == '0);
   assign status.found      = pick[BIT_IDX_W];

   assign rsp_status    = rsp_status_ff;
   assign rsp_id_res    = rsp_id_ff;
   assign rsp_free_left = free_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < WORD_COUNT; w++) begin
            used_ff[w] <= '0;
         end
         id_count_ff     <= CNT_W'(MAX_IDS);
         last_id_ff      <= ID_W'(MAX_IDS - 1);
         free_total_ff   <= CNT_W'(MAX_IDS);
         search_start_ff <= '0;
      end else if (cmd.cfg_write) begin
         for (int w = 0; w < WORD_COUNT; w++) begin
            used_ff[w] <= '0;
         end
         id_count_ff     <= new_count;
         last_id_ff      <= ID_W'(new_count - CNT_W'(1));
         free_total_ff   <= new_count;
         search_start_ff <= '0;
      end else if (scan_hit) begin
         used_ff[scan_word_ff][pick[BIT_IDX_W-1:0]] <= 1'b1;
         free_total_ff   <= free_total_ff - CNT_W'(1);
         search_start_ff <= (found_id == last_id_ff) ? '0 : found_id + ID_W'(1);
      end else if (cmd.free_exec && free_in_range && free_is_used) begin
         used_ff[free_word][free_bit] <= 1'b0;
         free_total_ff <= free_total_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_word_ff  <= search_start_ff[ID_W-1:BIT_IDX_W];
         scan_first_ff <= 1'b1;
      end else if (cmd.scan_step) begin
         scan_word_ff  <= (scan_word_ff == last_word) ? '0 : scan_word_ff + 1'b1;
         scan_first_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc_full) begin
         rsp_status_ff <= STATUS_FULL;
         rsp_id_ff     <= '0;
      end else if (scan_hit) begin
         rsp_status_ff <= STATUS_OK;
         rsp_id_ff     <= found_id;
      end else if (cmd.free_exec) begin
         rsp_id_ff <= '0;
         if (!free_in_range) begin
            rsp_status_ff <= STATUS_RANGE;
         end else if (!free_is_used) begin
            rsp_status_ff <= STATUS_UNALLOC;
         end else begin
            rsp_status_ff <= STATUS_OK;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      free_total_ff <= id_count_ff)
      else $error("free count above id_count");

   assert property (@(posedge clock) disable iff (reset)
      search_start_ff <= last_id_ff)
      else $error("search start outside the pool");

   assert property (@(posedge clock) disable iff (reset)
      scan_hit |=> free_total_ff == $past(free_total_ff) - CNT_W'(1))
      else $error("allocation did not take one ID from the free count");

endmodule

// ----- tb/nba_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator result checker
// Watches the request, response and id_count channels. It predicts every
// response from its own copy of the pool and compares the responses field by
// field.
// ----------------------------------------------------------------------------
module nba_result_checker (
   input  logic clock,
   input  logic reset,
   nba_req_if   req,
   nba_rsp_if   rsp,
   nba_csr_if   csr,
   output int   mismatches,
   output int   outstanding
);
   import nba_pkg::*;

   typedef struct packed {
      status_type            status;
      logic [ID_W-1:0]       id_res;
      logic [CNT_W-1:0]      free_left;
   } alloc_answer_type;

   logic [MAX_IDS-1:0] id_taken;
   logic [CNT_W-1:0]   pool_size;
   logic [CNT_W-1:0]   spare_ids;
   logic [ID_W-1:0]    next_start;
   alloc_answer_type   answers_due[$];

   task automatic report_mismatch(input string detail);
      mismatches++;
      $display("result check: %s", detail);
   endtask

   // A write of id_count clamps to 1..MAX_IDS and empties the pool.
   function automatic void clear_pool(input logic [CNT_W-1:0] written);
      if (written == 0) begin
         pool_size = CNT_W'(1);
      end else if (written > MAX_IDS) begin
         pool_size = CNT_W'(MAX_IDS);
      end else begin
         pool_size = written;
      end
      id_taken   = '0;
      spare_ids  = pool_size;
      next_start = '0;
   endfunction

   function automatic alloc_answer_type serve_request(input logic op,
                                                      input logic [ID_W-1:0] id);
      alloc_answer_type answer;
      int               n;
      bit               found;
      answer.status = STATUS_OK;
      answer.id_res = '0;
      found         = 1'b0;
      if (op == OP_ALLOC) begin
         if (spare_ids == 0) begin
            answer.status = STATUS_FULL;
         end else begin
            n = int'(next_start) % int'(pool_size);
            for (int k = 0; k < int'(pool_size); k++) begin
               if (!found && !id_taken[n]) begin
                  id_taken[n]   = 1'b1;
                  spare_ids     = spare_ids - CNT_W'(1);
                  next_start    = ID_W'((n + 1) % int'(pool_size));
                  answer.id_res = ID_W'(n);
                  found         = 1'b1;
               end
               n = (n + 1) % int'(pool_size);
            end
            if (!found) begin
               answer.status = STATUS_FULL;
            end
         end
      end else begin
         if (id >= pool_size) begin
            answer.status = STATUS_RANGE;
         end else if (!id_taken[id]) begin
            answer.status = STATUS_UNALLOC;
         end else begin
            id_taken[id] = 1'b0;
            spare_ids    = spare_ids + CNT_W'(1);
         end
      end
      answer.free_left = spare_ids;
      return answer;
   endfunction

   always @(posedge clock) begin
      alloc_answer_type due;
      if (reset) begin
         clear_pool(CNT_W'(MAX_IDS));
         answers_due.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (answers_due.size() == 0) begin
               report_mismatch("response with no request waiting");
            end else begin
               due = answers_due.pop_front();
               if (rsp.status !== due.status) begin
                  report_mismatch($sformatf("status expected %0d got %0d",
                                            due.status, rsp.status));
               end
               if (rsp.id_res !== due.id_res) begin
                  report_mismatch($sformatf("id_res expected %0d got %0d",
                                            due.id_res, rsp.id_res));
               end
               if (rsp.free_left !== due.free_left) begin
                  report_mismatch($sformatf("free_left expected %0d got %0d",
                                            due.free_left, rsp.free_left));
               end
            end
         end
         if (csr.valid && csr.ready) begin
            clear_pool(csr.id_count);
         end
         if (req.valid && req.ready) begin
            answers_due.push_back(serve_request(req.operation, req.id));
         end
      end
      outstanding = answers_due.size();
   end

endmodule

// ----- tb/next_fit_bitmap_id_allocator_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next-fit bitmap ID allocator core test
// Drives allocate and free requests through several pool sizes, with random
// idling on both channels. A checker beside the core predicts and compares
// every response. This module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module next_fit_bitmap_id_allocator_core_test;
   import nba_pkg::*;

   // An allocate scan stops at the first free ID it finds. Even with the receiver
   // idling at random, no legal run stays quiet up to STALL_LIMIT without some
   // handshake, so reaching it means the core hung.
   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 10;
   localparam int PICK_RANDOM = -1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nba_req_if req_if();
   nba_rsp_if rsp_if();
   nba_csr_if csr_if();

   int mismatches;
   int outstanding;

   // When gaps_on is low, neither side idles. The big fill phase runs that way
   // so that the core also sees a long stretch of back-to-back requests.
   bit              gaps_on;
   int              quiet_cycles;
   int              requests_sent;
   int              sizes_written;
   int              full_answers;
   logic            op_trail[$];
   logic [ID_W-1:0] held_ids[$];

   // Pool sizes for the random phases: the written value (PICK_RANDOM draws
   // one), whether the pool is first filled past full, and how many mixed
   // requests follow.
   int size_plan[PHASES] = '{0, 2047, 33, 32, 31, 100, 1024, PICK_RANDOM, 5, 1};
   bit fill_plan[PHASES] = '{1, 1, 1, 0, 1, 1, 0, 0, 1, 0};
   int mix_plan[PHASES]  = '{30, 120, 80, 80, 50, 80, 70, 50, 50, 30};

   always #4 clock = ~clock;

   next_fit_bitmap_id_allocator_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   nba_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr         (csr_if),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // With gaps_on high, the receiver is ready for a response about 70 percent of the time.
   always @(posedge clock) begin
      rsp_if.ready <= !gaps_on || ($urandom_range(99) >= 30);
   end

   // Only one request is in the core at a time, so responses come back in
   // request order. Remembering the IDs that allocates handed out lets most
   // frees name a live ID, which keeps the pool in its interesting states.
   always @(posedge clock) begin
      logic op;
      if (req_if.valid && req_if.ready) begin
         op_trail.push_back(req_if.operation);
      end
      if (rsp_if.valid && rsp_if.ready && op_trail.size() > 0) begin
         op = op_trail.pop_front();
         if (op == OP_ALLOC && rsp_if.status == STATUS_OK) begin
            held_ids.push_back(rsp_if.id_res);
         end
         if (rsp_if.status == STATUS_FULL) begin
            full_answers++;
         end
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Presents one request and returns at the edge where it was accepted. The
   // valid stays high afterwards, so that the next request can follow at once.
   task automatic send_request(input logic op, input logic [ID_W-1:0] id);
      while (gaps_on && $urandom_range(99) < 30) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.id        <= id;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      requests_sent++;
   endtask

   // Waits until every response is back, then writes id_count. The core is
   // idle once its last response has been taken, since every request answers.
   task automatic write_pool_size(input logic [CNT_W-1:0] value);
      req_if.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (outstanding != 0);
      csr_if.valid    <= 1'b1;
      csr_if.id_count <= value;
      @(posedge clock);
      while (!csr_if.ready) begin
         @(posedge clock);
      end
      csr_if.valid <= 1'b0;
      held_ids.delete();
      sizes_written++;
   endtask

   // Mixed traffic. The allocate share swings between fill and drain every
   // 40 requests. Frees mostly name a live ID, sometimes any in-range ID, and
   // sometimes any 10-bit value, which is how out-of-range frees arise.
   task automatic mixed_traffic(input int count, input int pool);
      int              alloc_share;
      int              pick;
      int              slot;
      logic [ID_W-1:0] id;
      alloc_share = 70;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            alloc_share = ((i / 40) % 2 == 0) ? 70 : 30;
         end
         if ($urandom_range(99) < alloc_share) begin
            send_request(OP_ALLOC, ID_W'($urandom));
         end else begin
            pick = $urandom_range(99);
            if (pick < 60 && held_ids.size() > 0) begin
               slot = $urandom_range(held_ids.size() - 1);
               id   = held_ids[slot];
               held_ids.delete(slot);
            end else if (pick < 85) begin
               id = ID_W'($urandom_range(pool - 1));
            end else begin
               id = ID_W'($urandom);
            end
            send_request(OP_FREE, id);
         end
      end
   endtask

   initial begin
      int written;
      int pool;
      req_if.valid     = 1'b0;
      req_if.operation = OP_ALLOC;
      req_if.id        = '0;
      csr_if.valid     = 1'b0;
      csr_if.id_count  = '0;
      gaps_on          = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part, on the reset pool of 1024 IDs first. An allocate with
      // an all-ones id shows that allocate ignores the field. Next-fit means
      // the allocate after a free still moves on to ID 2.
      send_request(OP_ALLOC, '1);
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, '1);
      send_request(OP_FREE, '0);
      send_request(OP_FREE, '0);
      send_request(OP_ALLOC, '0);

      // Writing zero gives a pool of one ID: full, out-of-range frees at both
      // ends of the id field, and a free that makes room again.
      write_pool_size('0);
      send_request(OP_ALLOC, '0);
      send_request(OP_ALLOC, '1);
      send_request(OP_FREE, ID_W'(1));
      send_request(OP_FREE, '1);
      send_request(OP_FREE, '0);
      send_request(OP_ALLOC, '0);

      // Three IDs: fill, hit full, then the search wraps past the end to find
      // the freed ID, and starts after it on the next allocate.
      write_pool_size(CNT_W'(3));
      repeat (4) send_request(OP_ALLOC, '0);
      send_request(OP_FREE, ID_W'(1));
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, ID_W'(2));
      send_request(OP_ALLOC, '0);

      // Random phases. Writes of 0 and 2047 check the clamping, and filling a
      // large pool before the mixed traffic forces allocates to scan and wrap
      // over many bitmap words.
      for (int p = 0; p < PHASES; p++) begin
         written = (size_plan[p] == PICK_RANDOM) ? $urandom_range(2, 1100) : size_plan[p];
         pool    = (written == 0) ? 1 : ((written > MAX_IDS) ? MAX_IDS : written);
         gaps_on = (p != 1);
         write_pool_size(CNT_W'(written));
         if (fill_plan[p]) begin
            repeat (pool + 2) send_request(OP_ALLOC, ID_W'($urandom));
         end
         gaps_on = 1'b1;
         mixed_traffic(mix_plan[p], pool);
      end

      req_if.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (outstanding != 0);
      repeat (40) @(posedge clock);

      $display("summary: %0d requests over %0d id_count writes, clamped values included",
               requests_sent, sizes_written);
      $display("summary: %0d allocates answered with the pool full", full_answers);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
